@@ hw/rtl/polynomial_bisection_root_core_assert.svh @@
// ----------------------------------------------------------------------------
// polynomial_bisection_root_core_assert.svh
// Assertion macros shared by the bisection root core RTL.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_BISECTION_ROOT_CORE_ASSERT_SVH
`define POLYNOMIAL_BISECTION_ROOT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbr assertion failed");
// next-cycle implication
`define PBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbr assertion failed");
`else
`define PBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/pbr_pkg.sv @@
// ----------------------------------------------------------------------------
// pbr_pkg
// Types and constants of the polynomial bisection root core.
// ----------------------------------------------------------------------------
package pbr_pkg;

    localparam int NCOEF     = 6;
    localparam int DEG_LIMIT = 5;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q  = 64'h0000_0001_0000_0000;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_POLY_DEGREE = 3'd0;
    localparam t_cfg_idx CFG_COEF_0      = 3'd1;
    localparam t_cfg_idx CFG_COEF_5      = 3'd6;
    localparam t_cfg_idx CFG_TOLERANCE   = 3'd7;

    localparam logic [2:0]  RST_POLY_DEGREE = 3'd2;
    localparam logic [31:0] RST_TOLERANCE   = 32'd429497;
    localparam logic [15:0] RST_COEF [NCOEF] = '{16'hFFFE, 16'h0000, 16'h0001,
                                                 16'h0000, 16'h0000, 16'h0000};

    typedef struct packed {
        logic start;
        logic scale;   // drop low 32 bits of the product
        logic half;    // first operand fits in 32 bits
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mul_rsp;

endpackage

@@ hw/rtl/pbr_if.sv @@
// ----------------------------------------------------------------------------
// pbr_if
// Valid/ready channels of the polynomial bisection root core.
// ----------------------------------------------------------------------------
interface pbr_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] range_low;
    logic signed [63:0] range_high;
    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface pbr_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] root_estimate;
    logic               exact_zero;
    logic [6:0]         pass_count;
    logic               limit_hit;
    modport source (output valid, root_estimate, exact_zero, pass_count, limit_hit,
                    input ready);
    modport sink   (input valid, root_estimate, exact_zero, pass_count, limit_hit,
                    output ready);
endinterface

interface pbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] reg_data;
    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

@@ hw/rtl/pbr_mul.sv @@
// ----------------------------------------------------------------------------
// pbr_mul
// Shared saturating Q32.32 multiplier: 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
`include "polynomial_bisection_root_core_assert.svh"

module pbr_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbr_pkg::t_mul_req i_req,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output pbr_pkg::t_mul_rsp o_rsp
);
    import pbr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_SAT} t_state;

    t_state       r_state;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic         r_scale;
    logic [1:0]   r_last;
    logic [1:0]   r_step;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic         r_pp_v;
    logic [127:0] r_acc;
    logic [63:0]  r_res;
    logic         r_done;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [127:0] pp_ext;
    logic [127:0] n_acc;
    logic [63:0]  sat_m;
    logic         sat_ovf;
    logic [63:0]  sat_res;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    assign op_a = r_step[1] ? r_ma[63:32] : r_ma[31:0];
    assign op_b = r_step[0] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_ext = {64'd0, r_pp};
            2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
            default: pp_ext = {r_pp, 64'd0};
        endcase
        n_acc = r_acc + pp_ext;
    end

    always_comb begin
        sat_m   = r_scale ? r_acc[95:32] : r_acc[63:0];
        sat_ovf = r_scale ? (|r_acc[127:96]) : (|r_acc[127:64]);
        if (r_neg) begin
            sat_res = (sat_ovf || (sat_m[63] && (|sat_m[62:0]))) ? SIGN64
                                                                 : (64'd0 - sat_m);
        end else begin
            sat_res = (sat_ovf || sat_m[63]) ? MAXPOS : sat_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pp_v  <= 1'b0;
        end else begin
            r_done <= (r_state == S_SAT);
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ma    <= mag64(i_a);
                        r_mb    <= mag64(i_b);
                        r_neg   <= i_a[63] ^ i_b[63];
                        r_scale <= i_req.scale;
                        r_last  <= i_req.half ? 2'd1 : 2'd3;
                        r_step  <= 2'd0;
                        r_acc   <= '0;
                        r_pp_v  <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_pp_v) begin
                        r_acc <= n_acc;
                    end
                    r_pp    <= op_a * op_b;
                    r_pp_sh <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
                    r_pp_v  <= 1'b1;
                    if (r_step == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_DRAIN: begin
                    r_acc   <= n_acc;
                    r_pp_v  <= 1'b0;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res   <= sat_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    `PBR_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == S_IDLE)
    `PBR_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_rsp.done, !o_rsp.done)
    `PBR_ASSERT_NEXT(a_sat_done, i_clk, i_rst_n, r_state == S_SAT, o_rsp.done)

endmodule

@@ hw/rtl/polynomial_bisection_root_core.sv @@
// ----------------------------------------------------------------------------
// polynomial_bisection_root_core
// Bisection search for a root of a configured integer polynomial in Q32.32.
//
// i_in carries one interval per transaction; o_out returns one result per
// interval; i_cfg writes degree, coefficients and tolerance; the user must
// write them only while idle, which the block itself does not enforce.
// i_in.ready is high only between searches. Each pass runs the states MID,
// WID and CHK, then, unless the width is within tolerance, an evaluation on
// the shared multiplier (two partial products per coefficient term, four
// per power update) and DECIDE. Up to MAX_PASSES + 1 evaluations.
// The result sits in an output register; a new interval is accepted while
// it waits, and a finished search holds until that register is free.
// Synchronous reset restores the default polynomial x^2 - 2 and tolerance.
// ----------------------------------------------------------------------------
`include "polynomial_bisection_root_core_assert.svh"

module polynomial_bisection_root_core #(
    parameter int MAX_DEGREE = 5,
    parameter int MAX_PASSES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbr_in_if.sink    i_in,
    pbr_out_if.source o_out,
    pbr_cfg_if.sink   i_cfg
);
    import pbr_pkg::*;

    localparam int PW      = $clog2(MAX_PASSES + 1);
    localparam int DEG_CAP = (MAX_DEGREE < DEG_LIMIT) ? MAX_DEGREE : DEG_LIMIT;

    typedef enum logic [3:0] {
        S_IDLE, S_MID, S_WID, S_CHK, S_CMUL, S_CWAIT, S_WMUL, S_WWAIT, S_DECIDE, S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_poly_degree;
    logic signed [15:0] r_coef [NCOEF];
    logic [31:0]        r_tolerance;

    logic [63:0]        r_lo;
    logic [63:0]        r_hi;
    logic [63:0]        r_mid;
    logic [63:0]        r_diff;
    logic               r_rev;
    logic [63:0]        r_width;
    logic [63:0]        r_sum;
    logic [63:0]        r_w;
    logic [2:0]         r_idx;
    logic [PW-1:0]      r_passes;
    logic               r_zero;
    logic               r_limit;

    logic               r_out_valid;
    logic [63:0]        r_out_root;
    logic               r_out_zero;
    logic [6:0]         r_out_count;
    logic               r_out_limit;

    logic [64:0]        mid_sum;
    logic [2:0]         deg_eff;
    logic [63:0]        coef_ext;
    logic [63:0]        n_sum;
    logic               out_load;
    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? SIGN64 : MAXPOS;
        end
        return s;
    endfunction

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_degree <= RST_POLY_DEGREE;
            r_tolerance   <= RST_TOLERANCE;
            for (int k = 0; k < NCOEF; k++) begin
                r_coef[k] <= RST_COEF[k];
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == CFG_POLY_DEGREE) begin
                r_poly_degree <= i_cfg.reg_data[2:0];
            end else if (i_cfg.reg_index inside {[CFG_COEF_0:CFG_COEF_5]}) begin
                r_coef[3'(i_cfg.reg_index - CFG_COEF_0)] <= i_cfg.reg_data[15:0];
            end else if (i_cfg.reg_index == CFG_TOLERANCE) begin
                r_tolerance <= i_cfg.reg_data;
            end
        end
    end

    // datapath helpers
    assign mid_sum  = {r_lo[63], r_lo} + {r_hi[63], r_hi};
    assign deg_eff  = (r_poly_degree > 3'(DEG_CAP)) ? 3'(DEG_CAP) : r_poly_degree;
    assign coef_ext = {{48{r_coef[r_idx][15]}}, r_coef[r_idx]};
    assign n_sum    = add_sat(r_sum, mul_rsp.result);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign mul_req.start = (r_state == S_CMUL) || (r_state == S_WMUL);
    assign mul_req.scale = (r_state == S_WMUL);
    assign mul_req.half  = (r_state == S_CMUL);
    assign mul_a         = (r_state == S_CMUL) ? coef_ext : r_w;
    assign mul_b         = (r_state == S_CMUL) ? r_w : r_mid;

    pbr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_lo     <= i_in.range_low;
                        r_hi     <= i_in.range_high;
                        r_passes <= '0;
                        r_state  <= S_MID;
                    end
                end
                S_MID: begin
                    r_mid   <= mid_sum[64:1];
                    r_diff  <= r_hi - r_lo;
                    r_rev   <= $signed(r_hi) < $signed(r_lo);
                    r_state <= S_WID;
                end
                S_WID: begin
                    r_width <= r_rev ? (64'd0 - r_diff) : r_diff;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_width < {32'd0, r_tolerance}) begin
                        r_zero  <= 1'b0;
                        r_limit <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_sum   <= '0;
                        r_w     <= ONE_Q;
                        r_idx   <= '0;
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (mul_rsp.done) begin
                        r_sum   <= n_sum;
                        r_state <= (r_idx == deg_eff) ? S_DECIDE : S_WMUL;
                    end
                end
                S_WMUL: r_state <= S_WWAIT;
                S_WWAIT: begin
                    if (mul_rsp.done) begin
                        r_w     <= mul_rsp.result;
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_CMUL;
                    end
                end
                S_DECIDE: begin
                    if (r_sum == 64'd0) begin
                        r_zero  <= 1'b1;
                        r_limit <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_passes >= PW'(MAX_PASSES)) begin
                        r_zero  <= 1'b0;
                        r_limit <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        if (!r_sum[63]) begin
                            r_hi <= r_mid;
                        end else begin
                            r_lo <= r_mid;
                        end
                        r_passes <= r_passes + 1'b1;
                        r_state  <= S_MID;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_root  <= r_mid;
                        r_out_zero  <= r_zero;
                        r_out_count <= 7'(r_passes);
                        r_out_limit <= r_limit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.root_estimate = r_out_root;
    assign o_out.exact_zero    = r_out_zero;
    assign o_out.pass_count    = r_out_count;
    assign o_out.limit_hit     = r_out_limit;

    `PBR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_MID)
    `PBR_ASSERT_NOW(a_pass_bound, i_clk, i_rst_n, r_state != S_IDLE, r_passes <= PW'(MAX_PASSES))
    `PBR_ASSERT_NOW(a_zero_no_limit, i_clk, i_rst_n, r_out_valid && r_out_zero, !r_out_limit)
    `PBR_ASSERT_NOW(a_mul_wait, i_clk, i_rst_n, mul_rsp.done,
                    (r_state == S_CWAIT) || (r_state == S_WWAIT))

endmodule
